// ===== sv/dbrf_pkg.sv =====
// Shared types, constants and a helper function for the DCT block rotate/flip block.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package dbrf_pkg;

  localparam int BlockSideDef = 8;
  localparam int CoefW        = 16;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTranspose = 2'd0,
    CfgMirrorX   = 2'd1,
    CfgMirrorY   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic bank;
    logic transpose;
    logic mirror_x;
    logic mirror_y;
  } blk_desc_t;

  function automatic logic [CoefW-1:0] neg_sat(input logic [CoefW-1:0] c);
    logic [CoefW-1:0] r;
    if (c == {1'b1, {(CoefW-1){1'b0}}}) begin
      r = {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      r = (~c) + {{(CoefW-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dbrf_if.sv =====
// Handshake channel interfaces for coefficients in, coefficients out and configuration.
// Depends on dbrf_pkg for field widths.
`default_nettype none

interface dbrf_coef_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [dbrf_pkg::CoefW-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

interface dbrf_coef_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dbrf_pkg::CoefW-1:0] result_coefficient;
  logic                              block_last;

  modport source (output valid, output result_coefficient, output block_last, input ready);
  modport sink   (input valid, input result_coefficient, input block_last, output ready);
endinterface

interface dbrf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dbrf_pkg::CfgIdxW-1:0]        index;
  logic [dbrf_pkg::CfgDataW-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/dbrf_store.sv =====
// Two-bank block store: one write port from the front, one registered read port for the back.
// Depends on dbrf_pkg.
`default_nettype none

module dbrf_store #(
  parameter int BLOCK_SIDE = dbrf_pkg::BlockSideDef
) (
  input  wire logic                                                clk_i,
  input  wire logic                                                wr_en_i,
  input  wire logic [$clog2(BLOCK_SIDE*BLOCK_SIDE):0]              wr_addr_i,
  input  wire logic [dbrf_pkg::CoefW-1:0]                          wr_data_i,
  input  wire logic                                                rd_en_i,
  input  wire logic [$clog2(BLOCK_SIDE*BLOCK_SIDE):0]              rd_addr_i,
  output      logic [dbrf_pkg::CoefW-1:0]                          rd_data_o
);
  import dbrf_pkg::*;

  localparam int AreaW = $clog2(BLOCK_SIDE * BLOCK_SIDE);
  localparam int Depth = 2 ** (AreaW + 1);

  logic [CoefW-1:0] mem_q [Depth];
  logic [CoefW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== sv/dbrf_front.sv =====
// Front end: configuration registers, coefficient intake, bank fill and block descriptors.
// Depends on dbrf_pkg and the channel interfaces in dbrf_if.
`default_nettype none

module dbrf_front #(
  parameter int BLOCK_SIDE = dbrf_pkg::BlockSideDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  dbrf_coef_in_if.sink                                in_i,
  dbrf_cfg_if.sink                                    cfg_i,
  output      logic                                   wr_en_o,
  output      logic [$clog2(BLOCK_SIDE*BLOCK_SIDE):0] wr_addr_o,
  output      logic [dbrf_pkg::CoefW-1:0]             wr_data_o,
  output      logic                                   push_o,
  output      dbrf_pkg::blk_desc_t                    desc_o,
  input  wire logic                                   release_i
);
  import dbrf_pkg::*;

  localparam int Area  = BLOCK_SIDE * BLOCK_SIDE;
  localparam int AreaW = $clog2(Area);
  localparam logic [AreaW-1:0] FillLast = AreaW'(Area - 1);

  logic [AreaW-1:0] fill_q, fill_d;
  logic             bank_q, bank_d;
  logic [1:0]       owned_q, owned_d;
  logic             transpose_q, transpose_d;
  logic             mirror_x_q, mirror_x_d;
  logic             mirror_y_q, mirror_y_d;
  logic             accept;
  logic             last;

  assign in_i.ready  = (owned_q != 2'd2);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign last        = (fill_q == FillLast);

  assign wr_en_o   = accept;
  assign wr_addr_o = {bank_q, fill_q};
  assign wr_data_o = in_i.coefficient;
  assign push_o    = accept && last;
  assign desc_o    = '{bank: bank_q, transpose: transpose_q,
                       mirror_x: mirror_x_q, mirror_y: mirror_y_q};

  always_comb begin
    fill_d      = fill_q;
    bank_d      = bank_q;
    owned_d     = owned_q + {1'b0, push_o} - {1'b0, release_i};
    transpose_d = transpose_q;
    mirror_x_d  = mirror_x_q;
    mirror_y_d  = mirror_y_q;
    if (accept) begin
      if (last) begin
        fill_d = '0;
        bank_d = ~bank_q;
      end else begin
        fill_d = fill_q + {{(AreaW-1){1'b0}}, 1'b1};
      end
    end
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgTranspose: transpose_d = cfg_i.data[0];
        CfgMirrorX:   mirror_x_d  = cfg_i.data[0];
        CfgMirrorY:   mirror_y_d  = cfg_i.data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      bank_q      <= 1'b0;
      owned_q     <= 2'd0;
      transpose_q <= 1'b0;
      mirror_x_q  <= 1'b0;
      mirror_y_q  <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      bank_q      <= bank_d;
      owned_q     <= owned_d;
      transpose_q <= transpose_d;
      mirror_x_q  <= mirror_x_d;
      mirror_y_q  <= mirror_y_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dbrf_queue.sv =====
// Two-entry descriptor queue between the front end and the readout engine.
// Depends on dbrf_pkg for the descriptor type.
`default_nettype none

module dbrf_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire dbrf_pkg::blk_desc_t desc_i,
  input  wire logic                pop_i,
  output      logic                empty_o,
  output      dbrf_pkg::blk_desc_t desc_o
);
  import dbrf_pkg::*;

  blk_desc_t  slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign empty_o = (count_q == 2'd0);
  assign desc_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== sv/dbrf_back.sv =====
// Readout engine: walks a stored block in output order, negates where mirrored, holds the result.
// Depends on dbrf_pkg and the output channel interface in dbrf_if.
`default_nettype none

module dbrf_back #(
  parameter int BLOCK_SIDE = dbrf_pkg::BlockSideDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   q_empty_i,
  input  wire dbrf_pkg::blk_desc_t                    q_desc_i,
  output      logic                                   q_pop_o,
  output      logic                                   release_o,
  output      logic                                   rd_en_o,
  output      logic [$clog2(BLOCK_SIDE*BLOCK_SIDE):0] rd_addr_o,
  input  wire logic [dbrf_pkg::CoefW-1:0]             rd_data_i,
  dbrf_coef_out_if.source                             out_o
);
  import dbrf_pkg::*;

  localparam int AreaW = $clog2(BLOCK_SIDE * BLOCK_SIDE);
  localparam int SideW = $clog2(BLOCK_SIDE);
  localparam logic [SideW-1:0] SideLast = SideW'(BLOCK_SIDE - 1);
  localparam logic [AreaW-1:0] SideA    = AreaW'(BLOCK_SIDE);

  logic             active_q;
  blk_desc_t        desc_q;
  logic [SideW-1:0] u_q, v_q;
  logic             s1_valid_q, s1_neg_q, s1_last_q;
  logic             out_valid_q, out_last_q;
  logic [CoefW-1:0] out_data_q;

  logic             out_free, s1_free, issue, finish, load;
  logic             last_u, last_v;
  logic [AreaW-1:0] ua, va, src;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_free  = !s1_valid_q || out_free;
  assign issue    = active_q && s1_free;
  assign last_u   = (u_q == SideLast);
  assign last_v   = (v_q == SideLast);
  assign finish   = issue && last_u && last_v;
  assign load     = !q_empty_i && (!active_q || finish);

  assign ua  = AreaW'(u_q);
  assign va  = AreaW'(v_q);
  assign src = desc_q.transpose ? (ua * SideA + va) : (va * SideA + ua);

  assign q_pop_o   = load;
  assign release_o = finish;
  assign rd_en_o   = issue;
  assign rd_addr_o = {desc_q.bank, src};

  assign out_o.valid              = out_valid_q;
  assign out_o.result_coefficient = out_data_q;
  assign out_o.block_last         = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      u_q         <= '0;
      v_q         <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        u_q      <= '0;
        v_q      <= '0;
      end else if (issue) begin
        if (last_u) begin
          u_q <= '0;
          if (last_v) begin
            active_q <= 1'b0;
          end else begin
            v_q <= v_q + {{(SideW-1){1'b0}}, 1'b1};
          end
        end else begin
          u_q <= u_q + {{(SideW-1){1'b0}}, 1'b1};
        end
      end
      if (s1_free) begin
        s1_valid_q <= issue;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= q_desc_i;
    end
    if (issue) begin
      s1_neg_q  <= (desc_q.mirror_x & u_q[0]) ^ (desc_q.mirror_y & v_q[0]);
      s1_last_q <= last_u && last_v;
    end
    if (out_free && s1_valid_q) begin
      out_data_q <= s1_neg_q ? neg_sat(rd_data_i) : rd_data_i;
      out_last_q <= s1_last_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dct_block_rotate_flip_top.sv =====
// Top level of the DCT block transpose and mirror unit.
// Depends on dbrf_pkg, dbrf_if, dbrf_store, dbrf_front, dbrf_queue and dbrf_back.
//
//   Channel  Direction  Contents
//   in_i     sink       coefficient, one per transfer, row-major within a block
//   out_o    source     result_coefficient and block_last, row-major within a block
//   cfg_i    sink       index and data of a register write (transpose, mirror_x, mirror_y)
//
// Coefficients are taken at one per cycle into a two-bank block store; a finished block is
// read out at one per cycle from its bank while the next block fills the other bank, unless
// the output stalls. Readout of a block begins once its descriptor has passed the queue.
// Intake stalls only while both banks hold blocks not yet fully read out.
// Reset clears the fill position, bank ownership, queue and registers; no clearing pass.
`default_nettype none

module dct_block_rotate_flip_top #(
  parameter int BLOCK_SIDE = dbrf_pkg::BlockSideDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  dbrf_coef_in_if.sink     in_i,
  dbrf_coef_out_if.source  out_o,
  dbrf_cfg_if.sink         cfg_i
);
  import dbrf_pkg::*;

  localparam int AreaW = $clog2(BLOCK_SIDE * BLOCK_SIDE);

  logic             wr_en, rd_en;
  logic [AreaW:0]   wr_addr, rd_addr;
  logic [CoefW-1:0] wr_data, rd_data;
  logic             push, pop, q_empty, release_bank;
  blk_desc_t        push_desc, pop_desc;

  dbrf_front #(.BLOCK_SIDE(BLOCK_SIDE)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .desc_o    (push_desc),
    .release_i (release_bank)
  );

  dbrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .empty_o (q_empty),
    .desc_o  (pop_desc)
  );

  dbrf_store #(.BLOCK_SIDE(BLOCK_SIDE)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dbrf_back #(.BLOCK_SIDE(BLOCK_SIDE)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_desc_i  (pop_desc),
    .q_pop_o   (pop),
    .release_o (release_bank),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
